/* rtl/csd_pkg.sv */
// Shared types and constants for the chi-square distance block.
package csd_pkg;

  localparam int ELEM_W = 16;
  localparam int SQ_W = 32;
  localparam int DEN_W = 17;
  localparam int SUM_W = 46;
  localparam int DIST_W = 33;
  localparam int CNT_OUT_W = 13;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [CNT_OUT_W-1:0] COUNT_MAX = {CNT_OUT_W{1'b1}};

  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic [DEN_W-1:0] den;
    logic last;
    logic drop;
  } csd_item_t;

endpackage

/* rtl/csd_fifo.sv */
// Small register queue that carries classified items from the front to the back.
module csd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  csd_pkg::csd_item_t  din,
  output logic                full,
  input  logic                pop,
  output csd_pkg::csd_item_t  dout,
  output logic                empty
);
  import csd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  csd_item_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic do_push;
  logic do_pop;

  assign full = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= CW'(DEPTH))
    else $error("Queue fill level exceeds its depth.");

  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("Item taken from an empty queue.");

endmodule

/* rtl/csd_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module csd_div #(
  parameter int NW = 48,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int IW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [IW-1:0] iter;
  logic [DW:0] rem_sh;
  logic fits;

  assign rem_sh = {rem, q[NW-1]};
  assign fits = (rem_sh >= {1'b0, dvs});
  assign quo = q;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      q <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      q <= {q[NW-2:0], fits};
      rem <= fits ? DW'(rem_sh - {1'b0, dvs}) : rem_sh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        iter <= IW'(NW);
      end else if (busy) begin
        iter <= iter - IW'(1);
        if (iter == IW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("Divider finished without having run.");

endmodule

/* rtl/csd_front.sv */
// Front end: takes element pairs, squares the difference, classifies and queues them.
module csd_front #(
  parameter int MAX_LEN = 4096,
  parameter int CNT_W = 13
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [csd_pkg::ELEM_W-1:0]        elem_a,
  input  logic [csd_pkg::ELEM_W-1:0]        elem_b,
  input  logic                              last_elem,
  input  logic                              q_pop,
  output csd_pkg::csd_item_t                q_item,
  output logic                              q_empty
);
  import csd_pkg::*;

  logic [ELEM_W-1:0] diff;
  logic [CNT_W-1:0] count;
  logic accept;
  logic drop;
  csd_item_t wr_item;

  assign accept = push && !full;
  assign drop = (count == CNT_W'(MAX_LEN));
  assign diff = (elem_a >= elem_b) ? elem_a - elem_b : elem_b - elem_a;

  always_comb begin
    wr_item.sq = SQ_W'(diff) * SQ_W'(diff);
    wr_item.den = DEN_W'(elem_a) + DEN_W'(elem_b);
    wr_item.last = last_elem;
    wr_item.drop = drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      if (last_elem) begin
        count <= '0;
      end else if (!drop) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  csd_fifo #(.DEPTH(4)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .din   (wr_item),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

endmodule

/* rtl/csd_back.sv */
// Back end: sums the terms, forms the mean and holds the result for the consumer.
module csd_back #(
  parameter int MAX_LEN = 4096,
  parameter int FRAC_BITS = 16,
  parameter int CNT_W = 13,
  parameter int DIV_NW = 48,
  parameter int DIV_DW = 17
) (
  input  logic                              clk,
  input  logic                              rst,
  input  csd_pkg::csd_item_t                q_item,
  input  logic                              q_empty,
  output logic                              q_pop,
  output logic                              div_start,
  output logic [DIV_NW-1:0]                 div_num,
  output logic [DIV_DW-1:0]                 div_den,
  input  logic                              div_busy,
  input  logic                              div_done,
  input  logic [DIV_NW-1:0]                 div_quo,
  output logic                              empty,
  input  logic                              pop,
  output logic [csd_pkg::DIST_W-1:0]        dist_value,
  output logic [csd_pkg::CNT_OUT_W-1:0]     elem_count,
  output logic                              len_overflow
);
  import csd_pkg::*;

  localparam int TERM_W = ELEM_W + FRAC_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TERM = 3'd1;
  localparam logic [2:0] ST_FIN  = 3'd2;
  localparam logic [2:0] ST_MEAN = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state, state_next;
  logic [SUM_W-1:0] sum, sum_next;
  logic [CNT_W-1:0] count, count_next;
  logic ovf, ovf_next;
  logic last_r, last_r_next;
  logic [DIST_W-1:0] mean, mean_next;
  logic res_valid, res_valid_next;
  logic load_out;
  logic [SUM_W:0] sum_add;
  logic [31:0] count_ext;

  assign sum_add = (SUM_W + 1)'(sum) + (SUM_W + 1)'(div_quo[TERM_W-1:0]);
  assign count_ext = 32'(count);
  assign empty = !res_valid;

  always_comb begin
    state_next = state;
    sum_next = sum;
    count_next = count;
    ovf_next = ovf;
    last_r_next = last_r;
    mean_next = mean;
    q_pop = 1'b0;
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    load_out = 1'b0;
    res_valid_next = res_valid && !pop;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          last_r_next = q_item.last;
          if (q_item.drop) begin
            ovf_next = 1'b1;
            state_next = q_item.last ? ST_FIN : ST_IDLE;
          end else begin
            count_next = count + CNT_W'(1);
            if (q_item.den == '0) begin
              state_next = q_item.last ? ST_FIN : ST_IDLE;
            end else begin
              div_start = 1'b1;
              div_num = DIV_NW'(q_item.sq) << FRAC_BITS;
              div_den = DIV_DW'(q_item.den);
              state_next = ST_TERM;
            end
          end
        end
      end
      ST_TERM: begin
        if (div_done) begin
          sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
          state_next = last_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (count == '0) begin
          mean_next = '0;
          state_next = ST_OUT;
        end else begin
          div_start = 1'b1;
          div_num = DIV_NW'(sum);
          div_den = DIV_DW'(count);
          state_next = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          mean_next = (|div_quo[DIV_NW-1:DIST_W]) ? DIST_MAX : div_quo[DIST_W-1:0];
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!res_valid || pop) begin
          load_out = 1'b1;
          res_valid_next = 1'b1;
          sum_next = '0;
          count_next = '0;
          ovf_next = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sum <= '0;
      count <= '0;
      ovf <= 1'b0;
      last_r <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      sum <= sum_next;
      count <= count_next;
      ovf <= ovf_next;
      last_r <= last_r_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mean <= mean_next;
    if (load_out) begin
      dist_value <= mean;
      elem_count <= (count_ext > 32'(COUNT_MAX)) ? COUNT_MAX : count_ext[CNT_OUT_W-1:0];
      len_overflow <= ovf;
    end
  end

  assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("Divider started while still busy.");

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(MAX_LEN))
    else $error("Pair count went past the maximum length.");

  assert property (@(posedge clk) disable iff (rst)
      (state == ST_OUT && res_valid && !pop) |=> (state == ST_OUT && res_valid))
    else $error("Result overwritten before it was taken.");

endmodule

/* rtl/chi_square_distance.sv */
// Top level of the streaming chi-square histogram distance.
// Each accepted pair goes into the input queue; the back end runs a pair with a nonzero sum
// through the shared one-bit-per-cycle divider of width N = max(46, 32 + FRAC_BITS), 48 by default,
// and skips the divider for a pair summing to zero or dropped.
// A last pair adds a divider pass for the mean, unless no pair was counted, and the output load.
// Synchronous reset clears the sum, the count, the queue and the result-valid flag.
module chi_square_distance #(
  parameter int MAX_LEN = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [csd_pkg::ELEM_W-1:0]        elem_a,
  input  logic [csd_pkg::ELEM_W-1:0]        elem_b,
  input  logic                              last_elem,
  output logic                              empty,
  input  logic                              pop,
  output logic [csd_pkg::DIST_W-1:0]        dist_value,
  output logic [csd_pkg::CNT_OUT_W-1:0]     elem_count,
  output logic                              len_overflow
);
  import csd_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int NUM_W = SQ_W + FRAC_BITS;
  localparam int DIV_NW = (NUM_W > SUM_W) ? NUM_W : SUM_W;
  localparam int DIV_DW = (CNT_W > DEN_W) ? CNT_W : DEN_W;

  csd_item_t q_item;
  logic q_empty;
  logic q_pop;
  logic div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic div_busy;
  logic div_done;
  logic [DIV_NW-1:0] div_quo;

  csd_front #(
    .MAX_LEN (MAX_LEN),
    .CNT_W   (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .elem_a    (elem_a),
    .elem_b    (elem_b),
    .last_elem (last_elem),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .q_empty   (q_empty)
  );

  csd_div #(
    .NW (DIV_NW),
    .DW (DIV_DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  csd_back #(
    .MAX_LEN   (MAX_LEN),
    .FRAC_BITS (FRAC_BITS),
    .CNT_W     (CNT_W),
    .DIV_NW    (DIV_NW),
    .DIV_DW    (DIV_DW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_item       (q_item),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .div_start    (div_start),
    .div_num      (div_num),
    .div_den      (div_den),
    .div_busy     (div_busy),
    .div_done     (div_done),
    .div_quo      (div_quo),
    .empty        (empty),
    .pop          (pop),
    .dist_value   (dist_value),
    .elem_count   (elem_count),
    .len_overflow (len_overflow)
  );

endmodule
